// ===== hw/rtl/tptd_pkg.sv =====
// tptd_pkg: shared types and constants for the two-point touch deglitcher
// holds the frame, result and register structs and the register index codes
// no dependencies
package tptd_pkg;

    localparam int unsigned TS_W     = 48;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned RUN_W    = 8;
    localparam int unsigned GAP_W    = 24;
    localparam int unsigned APB_AW   = 4;
    localparam int unsigned APB_DW   = 32;

    localparam logic [RUN_W-1:0] LIFT_FRAMES_RST        = 8'd2;
    localparam logic [RUN_W-1:0] SECOND_LIFT_FRAMES_RST = 8'd1;
    localparam logic [GAP_W-1:0] PRESS_GAP_US_RST       = 24'd70000;
    localparam logic [RUN_W-1:0] RUN_MAX                = 8'hFF;

    typedef enum logic [1:0] {
        REG_LIFT_FRAMES        = 2'd0,
        REG_SECOND_LIFT_FRAMES = 2'd1,
        REG_PRESS_GAP_US       = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [RUN_W-1:0] lift_frames;
        logic [RUN_W-1:0] second_lift_frames;
        logic [GAP_W-1:0] press_gap_us;
    } t_cfg;

    typedef struct packed {
        logic               controller_present;
        logic [1:0]         point_count;
        logic [COORD_W-1:0] first_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] second_y;
        logic [TS_W-1:0]    now_us;
    } t_frame;

    typedef struct packed {
        logic                      is_down;
        logic                      was_released;
        logic                      was_pressed;
        logic [1:0]                active_points;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos2_x;
        logic signed [COORD_W-1:0] pos2_y;
    } t_result;

endpackage

// ===== hw/rtl/tptd_core.sv =====
// tptd_core: contact state of the deglitcher and the per-frame update logic
// result is combinational from the frame and the state; state moves on i_step
// depends on tptd_pkg
module tptd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  tptd_pkg::t_cfg   i_cfg,
    input  tptd_pkg::t_frame i_frame,
    output tptd_pkg::t_result o_result
);
    import tptd_pkg::*;

    logic [COORD_W-1:0] r_held_x, r_held_y, r_held2_x, r_held2_y;
    logic [COORD_W-1:0] n_held_x, n_held_y, n_held2_x, n_held2_y;
    logic [RUN_W-1:0]   r_empty_run, n_empty_run;
    logic [RUN_W-1:0]   r_empty_run2, n_empty_run2;
    logic               r_primary_stable, n_primary_stable;
    logic               r_second_seen, n_second_seen;
    logic               r_second_stable, n_second_stable;
    logic [TS_W-1:0]    r_last_press, n_last_press;

    logic               raw;
    logic               two;
    logic [RUN_W-1:0]   run2_inc;
    logic [TS_W-1:0]    gap;
    logic               gap_ok;
    logic               pressed;

    assign raw = i_frame.controller_present && (i_frame.point_count != 2'd0);
    assign two = i_frame.controller_present && i_frame.point_count[1];

    // modulo 2^48 distance since the last accepted press
    assign gap    = i_frame.now_us - r_last_press;
    assign gap_ok = (gap[TS_W-1:GAP_W] != '0) || (gap[GAP_W-1:0] >= i_cfg.press_gap_us);

    assign run2_inc = (r_empty_run2 != RUN_MAX) ? r_empty_run2 + 8'd1 : r_empty_run2;

    always_comb begin
        n_held_x         = r_held_x;
        n_held_y         = r_held_y;
        n_held2_x        = r_held2_x;
        n_held2_y        = r_held2_y;
        n_empty_run      = r_empty_run;
        n_empty_run2     = r_empty_run2;
        n_primary_stable = r_primary_stable;
        n_second_seen    = r_second_seen;
        n_second_stable  = r_second_stable;
        n_last_press     = r_last_press;
        pressed          = 1'b0;

        if (raw) begin
            n_held_x = i_frame.first_x;
            n_held_y = i_frame.first_y;
        end

        // second contact only moves when a controller was read
        if (two) begin
            n_empty_run2  = '0;
            n_held2_x     = i_frame.second_x;
            n_held2_y     = i_frame.second_y;
            n_second_seen = 1'b1;
            if (r_second_seen) begin
                n_second_stable = 1'b1;
            end
        end else if (i_frame.controller_present) begin
            n_second_seen = 1'b0;
            if (r_empty_run2 <= i_cfg.second_lift_frames) begin
                n_empty_run2 = run2_inc;
                if (run2_inc > i_cfg.second_lift_frames) begin
                    n_second_stable = 1'b0;
                end
            end
        end

        if (raw) begin
            n_empty_run      = '0;
            n_primary_stable = 1'b1;
        end else if (r_empty_run < i_cfg.lift_frames) begin
            n_empty_run = r_empty_run + 8'd1;
            if (r_empty_run + 8'd1 >= i_cfg.lift_frames) begin
                n_primary_stable = 1'b0;
            end
        end

        if (n_primary_stable && !r_primary_stable && gap_ok) begin
            pressed      = 1'b1;
            n_last_press = i_frame.now_us;
        end
    end

    always_comb begin
        o_result.is_down       = n_primary_stable;
        o_result.was_released  = !n_primary_stable && r_primary_stable;
        o_result.was_pressed   = pressed;
        o_result.active_points = !n_primary_stable ? 2'd0 : (n_second_stable ? 2'd2 : 2'd1);
        o_result.pos_x         = signed'(n_held_x);
        o_result.pos_y         = signed'(n_held_y);
        o_result.pos2_x        = signed'(n_held2_x);
        o_result.pos2_y        = signed'(n_held2_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x         <= '0;
            r_held_y         <= '0;
            r_held2_x        <= '0;
            r_held2_y        <= '0;
            r_empty_run      <= '0;
            r_empty_run2     <= '0;
            r_primary_stable <= 1'b0;
            r_second_seen    <= 1'b0;
            r_second_stable  <= 1'b0;
            r_last_press     <= '0;
        end else if (i_step) begin
            r_held_x         <= n_held_x;
            r_held_y         <= n_held_y;
            r_held2_x        <= n_held2_x;
            r_held2_y        <= n_held2_y;
            r_empty_run      <= n_empty_run;
            r_empty_run2     <= n_empty_run2;
            r_primary_stable <= n_primary_stable;
            r_second_seen    <= n_second_seen;
            r_second_stable  <= n_second_stable;
            r_last_press     <= n_last_press;
        end
    end

`ifndef SYNTH
    a_raw_sets_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && raw |=> r_primary_stable && (r_empty_run == '0))
        else $error("frame with a point did not set the primary down");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_empty_run) && $stable(r_primary_stable)
                    && $stable(r_last_press) && $stable(r_second_stable))
        else $error("contact state moved without a frame");

    a_absent_keeps_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !i_frame.controller_present |=> $stable(r_second_stable)
            && $stable(r_second_seen) && $stable(r_empty_run2) && $stable(r_held2_x))
        else $error("second contact changed with no controller");

    a_press_stamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.was_pressed |=> r_last_press == $past(i_frame.now_us))
        else $error("accepted press did not record its timestamp");
`endif

endmodule

// ===== hw/rtl/two_point_touch_deglitcher.sv =====
// two_point_touch_deglitcher: top level with register port and frame pipeline
// instantiates tptd_core; depends on tptd_pkg
//
// usage:
//   frames enter on the input channel (i_in_valid / o_in_stall), one request
//   per touch-controller frame; each frame gives exactly one result request on
//   the output channel (o_out_valid / i_out_stall), in order.
//   an accepted frame is held in the input register; when that register
//   advances, its result is computed by the contact logic and lands in the
//   output register. throughput is one frame per cycle while the receiver
//   does not stall; the contact state steps in the same cycle as the result
//   is registered. while the receiver stalls, the output register holds its
//   result and the input register still takes one more frame; further frames
//   are stalled. registers (lift_frames, second_lift_frames, press_gap_us)
//   sit at byte addresses 0, 4, 8 of the apb port and are to be written only
//   while idle, which the user must ensure; the block does not enforce it.
//   synchronous active-low reset empties both registers, clears all contact
//   state and loads the register defaults 2, 1 and 70000.
module two_point_touch_deglitcher (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tptd_pkg::APB_AW-1:0]       paddr,
    input  logic [tptd_pkg::APB_DW-1:0]       pwdata,
    output logic [tptd_pkg::APB_DW-1:0]       prdata,
    output logic                              pready,
    // frame channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_controller_present,
    input  logic [1:0]                        i_point_count,
    input  logic [tptd_pkg::COORD_W-1:0]      i_first_x,
    input  logic [tptd_pkg::COORD_W-1:0]      i_first_y,
    input  logic [tptd_pkg::COORD_W-1:0]      i_second_x,
    input  logic [tptd_pkg::COORD_W-1:0]      i_second_y,
    input  logic [tptd_pkg::TS_W-1:0]         i_now_us,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_is_down,
    output logic                              o_was_released,
    output logic                              o_was_pressed,
    output logic [1:0]                        o_active_points,
    output logic signed [tptd_pkg::COORD_W-1:0] o_pos_x,
    output logic signed [tptd_pkg::COORD_W-1:0] o_pos_y,
    output logic signed [tptd_pkg::COORD_W-1:0] o_pos2_x,
    output logic signed [tptd_pkg::COORD_W-1:0] o_pos2_y
);
    import tptd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    logic     r_in_valid;
    t_frame   r_in;
    logic     r_out_valid;
    t_result  r_out;
    t_result  core_result;
    logic     advance;
    logic     in_acc;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lift_frames        <= LIFT_FRAMES_RST;
            r_cfg.second_lift_frames <= SECOND_LIFT_FRAMES_RST;
            r_cfg.press_gap_us       <= PRESS_GAP_US_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_LIFT_FRAMES:        r_cfg.lift_frames <= pwdata[RUN_W-1:0];
                REG_SECOND_LIFT_FRAMES: r_cfg.second_lift_frames <= pwdata[RUN_W-1:0];
                REG_PRESS_GAP_US:       r_cfg.press_gap_us <= pwdata[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LIFT_FRAMES:
                prdata = {{(APB_DW-RUN_W){1'b0}}, r_cfg.lift_frames};
            REG_SECOND_LIFT_FRAMES:
                prdata = {{(APB_DW-RUN_W){1'b0}}, r_cfg.second_lift_frames};
            REG_PRESS_GAP_US:
                prdata = {{(APB_DW-GAP_W){1'b0}}, r_cfg.press_gap_us};
            default:
                prdata = '0;
        endcase
    end

    // input register moves on when the output register is empty or draining
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in.controller_present <= i_controller_present;
            r_in.point_count        <= i_point_count;
            r_in.first_x            <= i_first_x;
            r_in.first_y            <= i_first_y;
            r_in.second_x           <= i_second_x;
            r_in.second_y           <= i_second_y;
            r_in.now_us             <= i_now_us;
        end
        if (advance) begin
            r_out <= core_result;
        end
    end

    tptd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_cfg    (r_cfg),
        .i_frame  (r_in),
        .o_result (core_result)
    );

    assign o_out_valid     = r_out_valid;
    assign o_is_down       = r_out.is_down;
    assign o_was_released  = r_out.was_released;
    assign o_was_pressed   = r_out.was_pressed;
    assign o_active_points = r_out.active_points;
    assign o_pos_x         = r_out.pos_x;
    assign o_pos_y         = r_out.pos_y;
    assign o_pos2_x        = r_out.pos2_x;
    assign o_pos2_y        = r_out.pos2_y;

endmodule

// ===== sim/tptd_tb_pkg.sv =====
`timescale 1ns / 100ps
// tptd_tb_pkg: result scoreboard for the two-point touch deglitcher testbench
// keeps its own copy of the contact state, predicts each frame's result, checks the dut
// depends on tptd_pkg
package tptd_tb_pkg;
    import tptd_pkg::*;

    // register slot past the last one, writes there must be ignored
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    class touch_report_checker;
        logic [RUN_W-1:0]   lift_frames;
        logic [RUN_W-1:0]   second_lift_frames;
        logic [GAP_W-1:0]   press_gap_us;
        logic [COORD_W-1:0] held_x, held_y, held2_x, held2_y;
        logic [RUN_W-1:0]   empty_run, empty_run2;
        logic               primary_down, second_seen, second_stable;
        logic [TS_W-1:0]    last_press_us;
        t_result            pending_reports[$];
        int unsigned        faults, frames_checked, presses, releases;

        function new();
            lift_frames        = LIFT_FRAMES_RST;
            second_lift_frames = SECOND_LIFT_FRAMES_RST;
            press_gap_us       = PRESS_GAP_US_RST;
            held_x = '0; held_y = '0; held2_x = '0; held2_y = '0;
            empty_run = '0; empty_run2 = '0;
            primary_down = 1'b0; second_seen = 1'b0; second_stable = 1'b0;
            last_press_us = '0;
            faults = 0; frames_checked = 0; presses = 0; releases = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [APB_DW-1:0] value);
            case (idx)
                REG_LIFT_FRAMES:        lift_frames = value[RUN_W-1:0];
                REG_SECOND_LIFT_FRAMES: second_lift_frames = value[RUN_W-1:0];
                REG_PRESS_GAP_US:       press_gap_us = value[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the contact state by one frame and queue the result it gives
        function void note_frame(t_frame f);
            logic            touched;
            logic            was_down;
            logic [TS_W-1:0] since_press;
            t_result         r;
            touched = 1'b0;
            r = '0;
            if (f.controller_present) begin
                if (f.point_count != 2'd0) begin
                    touched = 1'b1;
                    held_x = f.first_x;
                    held_y = f.first_y;
                end
                if (f.point_count >= 2'd2) begin
                    empty_run2 = '0;
                    held2_x = f.second_x;
                    held2_y = f.second_y;
                    if (second_seen) second_stable = 1'b1;
                    second_seen = 1'b1;
                end else begin
                    second_seen = 1'b0;
                    if (empty_run2 <= second_lift_frames) begin
                        if (empty_run2 != RUN_MAX) empty_run2 = empty_run2 + 1'b1;
                        if (empty_run2 > second_lift_frames) second_stable = 1'b0;
                    end
                end
            end
            was_down = primary_down;
            if (touched) begin
                empty_run = '0;
                primary_down = 1'b1;
            end else if (empty_run < lift_frames) begin
                empty_run = empty_run + 1'b1;
                if (empty_run >= lift_frames) primary_down = 1'b0;
            end
            // gap is taken modulo the timestamp width
            since_press = f.now_us - last_press_us;
            if (primary_down && !was_down && since_press >= press_gap_us) begin
                r.was_pressed = 1'b1;
                last_press_us = f.now_us;
                presses++;
            end
            r.is_down = primary_down;
            r.was_released = !primary_down && was_down;
            if (r.was_released) releases++;
            r.active_points = primary_down ? (second_stable ? 2'd2 : 2'd1) : 2'd0;
            r.pos_x = held_x;
            r.pos_y = held_y;
            r.pos2_x = held2_x;
            r.pos2_y = held2_y;
            pending_reports.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] exp, logic [15:0] got);
            if (exp !== got) begin
                faults++;
                $display("%0t: %s expected %h got %h", $time, field, exp, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result exp;
            if (pending_reports.size() == 0) begin
                faults++;
                $display("%0t: result with no frame pending, got %h", $time, got);
            end else begin
                exp = pending_reports.pop_front();
                frames_checked++;
                compare_field("is_down", exp.is_down, got.is_down);
                compare_field("was_released", exp.was_released, got.was_released);
                compare_field("was_pressed", exp.was_pressed, got.was_pressed);
                compare_field("active_points", exp.active_points, got.active_points);
                compare_field("pos_x", exp.pos_x, got.pos_x);
                compare_field("pos_y", exp.pos_y, got.pos_y);
                compare_field("pos2_x", exp.pos2_x, got.pos2_x);
                compare_field("pos2_y", exp.pos2_y, got.pos2_y);
            end
        endfunction
    endclass

endpackage

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// tb: top-level testbench for two_point_touch_deglitcher
// drives frames, register writes and output stalls; results checked by tptd_tb_pkg
// depends on tptd_pkg, tptd_tb_pkg and the rtl
module tb;
    import tptd_pkg::*;
    import tptd_tb_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned HOLD_CYCLES     = 64;
    localparam int unsigned ITEMS_PER_PHASE = 150;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [APB_AW-1:0]  paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    t_frame             frame_drv;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_is_down, o_was_released, o_was_pressed;
    logic [1:0]         o_active_points;
    logic signed [COORD_W-1:0] o_pos_x, o_pos_y, o_pos2_x, o_pos2_y;
    t_result            dut_report;

    touch_report_checker touch_sb;
    int unsigned        cycle_count = 0;
    int unsigned        frames_sent = 0;
    int unsigned        settings_applied = 0;
    int unsigned        gap_pct = 34;
    int unsigned        stall_pct = 34;
    int unsigned        hold_left = 0;
    logic [TS_W-1:0]    now_stamp;

    two_point_touch_deglitcher dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_controller_present (frame_drv.controller_present),
        .i_point_count        (frame_drv.point_count),
        .i_first_x            (frame_drv.first_x),
        .i_first_y            (frame_drv.first_y),
        .i_second_x           (frame_drv.second_x),
        .i_second_y           (frame_drv.second_y),
        .i_now_us             (frame_drv.now_us),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_is_down            (o_is_down),
        .o_was_released       (o_was_released),
        .o_was_pressed        (o_was_pressed),
        .o_active_points      (o_active_points),
        .o_pos_x              (o_pos_x),
        .o_pos_y              (o_pos_y),
        .o_pos2_x             (o_pos2_x),
        .o_pos2_y             (o_pos2_y)
    );

    assign dut_report = {o_is_down, o_was_released, o_was_pressed, o_active_points,
                         o_pos_x, o_pos_y, o_pos2_x, o_pos2_y};

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) touch_sb.note_frame(frame_drv);
            if (o_out_valid && !i_out_stall) touch_sb.check_result(dut_report);
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left != 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else begin
                i_out_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    task automatic send_frame(input t_frame f);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        frame_drv = f;
        do @(posedge i_clk); while (o_in_stall);
        frames_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (touch_sb.pending_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        touch_sb.write_register(idx, value);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // upper data bits are noise, only the register width may land
    task automatic apply_settings(input logic [RUN_W-1:0] rel, input logic [RUN_W-1:0] rel2,
                                  input logic [GAP_W-1:0] gap);
        wait_drained();
        apb_write(REG_LIFT_FRAMES, {24'($urandom), rel});
        apb_write(REG_SECOND_LIFT_FRAMES, {24'($urandom), rel2});
        apb_write(REG_PRESS_GAP_US, {8'($urandom), gap});
        settings_applied++;
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return COORD_W'($urandom);
    endfunction

    function automatic t_frame fixed_frame(input logic present, input logic [1:0] count,
                                           input logic [COORD_W-1:0] fx, fy, sx, sy,
                                           input logic [TS_W-1:0] stamp);
        t_frame f;
        f.controller_present = present;
        f.point_count = count;
        f.first_x = fx;
        f.first_y = fy;
        f.second_x = sx;
        f.second_y = sy;
        f.now_us = stamp;
        return f;
    endfunction

    function automatic t_frame random_frame(input logic present, input logic [1:0] count);
        return fixed_frame(present, count, rand_coord(), rand_coord(), rand_coord(),
                           rand_coord(), now_stamp);
    endfunction

    // mostly frame-period steps, sometimes long pauses or a jump anywhere in the range
    task automatic advance_stamp();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70) now_stamp += $urandom_range(20000, 1);
        else if (pick < 90) now_stamp += $urandom_range(200000);
        else if (pick < 97) now_stamp += $urandom_range(1 << 25);
        else now_stamp = TS_W'({$urandom, $urandom});
    endtask

    // one finger down for a while, maybe a second one, then lift-off
    task automatic touch_gesture();
        int unsigned hold_len, lift_len, i, pick;
        logic        two_fingers;
        hold_len = $urandom_range(12, 1);
        lift_len = $urandom_range(6);
        two_fingers = 1'($urandom_range(1));
        for (i = 0; i < hold_len; i++) begin
            pick = $urandom_range(99);
            if (pick < 8) two_fingers = !two_fingers;
            advance_stamp();
            if (pick >= 90) send_frame(random_frame(1'b1, 2'd0));
            else if (pick >= 85) send_frame(random_frame(1'b0, 2'($urandom_range(3))));
            else if (two_fingers) send_frame(random_frame(1'b1, $urandom_range(1) ? 2'd3 : 2'd2));
            else send_frame(random_frame(1'b1, 2'd1));
        end
        for (i = 0; i < lift_len; i++) begin
            advance_stamp();
            if ($urandom_range(9) == 0) send_frame(random_frame(1'b0, 2'($urandom_range(3))));
            else send_frame(random_frame(1'b1, 2'd0));
        end
    endtask

    task automatic run_traffic(input int unsigned n);
        int unsigned stop_at;
        stop_at = frames_sent + n;
        while (frames_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                touch_gesture();
            end else begin
                advance_stamp();
                send_frame(random_frame(1'($urandom_range(1)), 2'($urandom_range(3))));
            end
        end
    endtask

    // reset defaults: release after 2, second after more than 1, gap 70000
    task automatic directed_frames();
        send_frame(fixed_frame(1'b1, 2'd1, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 48'd70000));
        send_frame(fixed_frame(1'b1, 2'd3, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 48'd70001));
        send_frame(fixed_frame(1'b1, 2'd2, 16'h1234, 16'h5678, 16'h0000, 16'hFFFF, 48'd70002));
        // no controller: counts empty, second contact frozen
        send_frame(fixed_frame(1'b0, 2'd2, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 48'd70003));
        send_frame(fixed_frame(1'b1, 2'd1, 16'h8000, 16'h7FFF, 16'h0001, 16'h0002, 48'd70004));
        send_frame(fixed_frame(1'b1, 2'd0, 16'h0003, 16'h0004, 16'h0005, 16'h0006, 48'd70005));
        send_frame(fixed_frame(1'b1, 2'd0, 16'h0007, 16'h0008, 16'h0009, 16'h000A, 48'd70006));
        // press one microsecond short of the gap
        send_frame(fixed_frame(1'b1, 2'd1, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 48'd139999));
        send_frame(fixed_frame(1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 48'd140000));
        send_frame(fixed_frame(1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 48'd140001));
        send_frame(fixed_frame(1'b1, 2'd2, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF,
                               48'hFFFF_FFFF_FFF0));
        send_frame(fixed_frame(1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               48'hFFFF_FFFF_FFF8));
        send_frame(fixed_frame(1'b1, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               48'hFFFF_FFFF_FFFF));
        // timestamp wrapped, gap only 0x30
        send_frame(fixed_frame(1'b1, 2'd1, 16'h0F0F, 16'hF0F0, 16'h0000, 16'h0000, 48'h20));
        send_frame(fixed_frame(1'b0, 2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 48'h21));
        send_frame(fixed_frame(1'b0, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 48'h22));
        // across the wrap, exactly the gap
        send_frame(fixed_frame(1'b1, 2'd1, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 48'd69984));
        send_frame(fixed_frame(1'b1, 2'd2, 16'h5555, 16'h6666, 16'h7777, 16'h8888, 48'd69985));
        send_frame(fixed_frame(1'b1, 2'd3, 16'h9999, 16'hAAAA, 16'hBBBB, 16'hCCCC, 48'd69986));
        send_frame(fixed_frame(1'b1, 2'd1, 16'hDDDD, 16'hEEEE, 16'h0000, 16'h0000, 48'd69987));
        send_frame(fixed_frame(1'b1, 2'd1, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 48'd69988));
        now_stamp = 48'd69990;
    endtask

    initial begin
        touch_sb = new();
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        frame_drv = '0;
        now_stamp = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        directed_frames();
        run_traffic(ITEMS_PER_PHASE);

        // long stretch with no idling on either side
        apply_settings(8'd1, 8'd0, 24'd0);
        gap_pct = 0;
        stall_pct = 0;
        run_traffic(ITEMS_PER_PHASE);

        // largest lift and gap settings, and a long receiver hold-off so the block backs up
        apply_settings(8'd255, 8'd254, 24'hFFFFFF);
        stall_pct = 34;
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        run_traffic(ITEMS_PER_PHASE / 2);
        gap_pct = 34;
        run_traffic(ITEMS_PER_PHASE / 2);

        // primary never releases, second never releases by count
        apply_settings(8'd0, 8'd255, 24'd1000);
        apb_write(REG_UNMAPPED, 32'hFFFF_FFFF);
        run_traffic(ITEMS_PER_PHASE);

        apply_settings(8'($urandom_range(8, 1)), 8'($urandom_range(6)),
                       24'($urandom_range(60000)));
        run_traffic(ITEMS_PER_PHASE);

        wait_drained();
        $display("checked %0d frames over %0d register settings plus reset defaults",
                 touch_sb.frames_checked, settings_applied);
        $display("predicted %0d accepted press edges and %0d releases",
                 touch_sb.presses, touch_sb.releases);
        if (touch_sb.faults == 0 && touch_sb.pending_reports.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
